>>> rtl/msf_pkg.sv
`default_nettype none
package msf_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int DELAY_W   = 16;
	localparam int PPU_W     = 8;
	localparam int FIELD_W   = 15;
	localparam int NUM_GROUPS = 3;

	localparam logic [DELAY_W-1:0] RST_G0_DELAY = 16'd10;
	localparam logic [DELAY_W-1:0] RST_G1_DELAY = 16'd11;
	localparam logic [DELAY_W-1:0] RST_G2_DELAY = 16'd12;
	localparam logic [PPU_W-1:0]   RST_PPU      = 8'd50;
	localparam logic [DELAY_W-1:0] RST_LIMIT    = 16'd245;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_G0_DELAY = 3'd0,
		CFG_G1_DELAY = 3'd1,
		CFG_G2_DELAY = 3'd2,
		CFG_PPU      = 3'd3,
		CFG_LIMIT    = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		REQ_TARGET = 1'b0,
		REQ_TICK   = 1'b1
	} req_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic load_tgt;
		logic walk_start;
		logic walk_en;
	} cmd_t;

	typedef struct packed {
		logic last_motor;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/multi_stepper_position_follower.sv
`default_nettype none
// Channel   Handshake              Payload
// request   start / busy           req_type, motor_index, target_height, elapsed_count
// result    done (1-cycle strobe)  step_levels, dir_levels
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A target write completes in the cycle it is taken; busy stays low.
// A tick walks the motors one per clock through one shared update unit;
// busy stays high during the walk, done strobes in the cycle after the last motor,
// when a new request can already be taken.
// Reset (arst_n low) clears all targets, positions, counters and levels.
// done is not held: the receiver takes each beat in its strobe cycle.
module multi_stepper_position_follower #(
	parameter int NUM_MOTORS  = 15,
	parameter int GROUP_SIZE  = 5,
	parameter int HEIGHT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          req_type,
	input  wire logic [3:0]                    motor_index,
	input  wire logic [15:0]                   target_height,
	input  wire logic [15:0]                   elapsed_count,
	output logic                               done,
	output logic [msf_pkg::FIELD_W-1:0]        step_levels,
	output logic [msf_pkg::FIELD_W-1:0]        dir_levels,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [msf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);
	import msf_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	msf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	msf_datapath #(
		.NUM_MOTORS  (NUM_MOTORS),
		.GROUP_SIZE  (GROUP_SIZE),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.motor_index   (motor_index),
		.target_height (target_height),
		.elapsed_count (elapsed_count),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.step_levels   (step_levels),
		.dir_levels    (dir_levels)
	);

endmodule
`default_nettype wire

>>> rtl/msf_ctrl.sv
`default_nettype none
module msf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            req_type,
	input  wire msf_pkg::status_t status,
	output msf_pkg::cmd_t        cmd,
	output logic                 busy,
	output logic                 done
);
	import msf_pkg::*;

	state_t state_q, state_nxt;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.walk_en && status.last_motor;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_t'(req_type) == REQ_TICK) begin
						cmd.walk_start = 1'b1;
						state_nxt      = ST_WALK;
					end else begin
						cmd.load_tgt = 1'b1;
					end
				end
			end
			ST_WALK: begin
				cmd.walk_en = 1'b1;
				if (status.last_motor)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

>>> rtl/msf_datapath.sv
`default_nettype none
module msf_datapath #(
	parameter int NUM_MOTORS  = 15,
	parameter int GROUP_SIZE  = 5,
	parameter int HEIGHT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire msf_pkg::cmd_t                 cmd,
	output msf_pkg::status_t                   status,
	input  wire logic [3:0]                    motor_index,
	input  wire logic [15:0]                   target_height,
	input  wire logic [15:0]                   elapsed_count,
	input  wire logic                          cfg_we,
	input  wire logic [msf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data,
	output logic [msf_pkg::FIELD_W-1:0]        step_levels,
	output logic [msf_pkg::FIELD_W-1:0]        dir_levels
);
	import msf_pkg::*;

	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int GI_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int CMP_W = (HEIGHT_BITS > DELAY_W) ? HEIGHT_BITS : DELAY_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MOTORS - 1);
	localparam logic [GI_W-1:0]  LAST_GI  = GI_W'(GROUP_SIZE - 1);
	localparam logic [1:0]       GRP_NONE = 2'(NUM_GROUPS);

	logic [DELAY_W-1:0] g0_delay_q, g1_delay_q, g2_delay_q, limit_q;
	logic [PPU_W-1:0]   ppu_q;

	logic [HEIGHT_BITS-1:0] tgt_q [NUM_MOTORS];
	logic [HEIGHT_BITS-1:0] pos_q [NUM_MOTORS];
	logic [PPU_W-1:0]       cnt_q [NUM_MOTORS];
	logic [NUM_MOTORS-1:0]  step_q, dir_q;

	logic [IDX_W-1:0] idx_q;
	logic [GI_W-1:0]  gi_q;
	logic [1:0]       grp_q;      // GRP_NONE once past the gated groups
	logic [NUM_GROUPS-1:0] open_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g0_delay_q <= RST_G0_DELAY;
			g1_delay_q <= RST_G1_DELAY;
			g2_delay_q <= RST_G2_DELAY;
			ppu_q      <= RST_PPU;
			limit_q    <= RST_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_G0_DELAY: g0_delay_q <= cfg_data;
				CFG_G1_DELAY: g1_delay_q <= cfg_data;
				CFG_G2_DELAY: g2_delay_q <= cfg_data;
				CFG_PPU:      ppu_q      <= cfg_data[PPU_W-1:0];
				CFG_LIMIT:    limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// current motor
	logic [HEIGHT_BITS-1:0] cur_tgt, cur_pos, nxt_pos;
	logic [PPU_W:0]         cnt_inc;
	logic                   grp_open, moving, wrap, lower;

	always_comb begin
		cur_tgt  = tgt_q[idx_q];
		cur_pos  = pos_q[idx_q];
		grp_open = (grp_q != GRP_NONE) && open_q[grp_q];
		moving   = grp_open && (CMP_W'(cur_tgt) <= CMP_W'(limit_q)) && (cur_tgt != cur_pos);
		cnt_inc  = {1'b0, cnt_q[idx_q]} + (PPU_W+1)'(1);
		wrap     = cnt_inc > {1'b0, ppu_q};
		lower    = cur_tgt < cur_pos;
		nxt_pos  = lower ? cur_pos - HEIGHT_BITS'(1) : cur_pos + HEIGHT_BITS'(1);
	end

	assign status.last_motor = (idx_q == LAST_IDX);

	// walk sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			gi_q   <= '0;
			grp_q  <= '0;
			open_q <= '0;
		end else if (cmd.walk_start) begin
			idx_q     <= '0;
			gi_q      <= '0;
			grp_q     <= '0;
			open_q[0] <= elapsed_count > g0_delay_q;
			open_q[1] <= (elapsed_count > g0_delay_q) && (elapsed_count > g1_delay_q);
			open_q[2] <= (elapsed_count > g0_delay_q) && (elapsed_count > g1_delay_q)
				&& (elapsed_count > g2_delay_q);
		end else if (cmd.walk_en) begin
			idx_q <= idx_q + IDX_W'(1);
			if (gi_q == LAST_GI) begin
				gi_q <= '0;
				if (grp_q != GRP_NONE)
					grp_q <= grp_q + 2'd1;
			end else begin
				gi_q <= gi_q + GI_W'(1);
			end
		end
	end

	// per-motor control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dir_q  <= '0;
			for (int i = 0; i < NUM_MOTORS; i++) begin
				tgt_q[i] <= '0;
				pos_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (cmd.load_tgt && (int'(motor_index) < NUM_MOTORS))
				tgt_q[IDX_W'(motor_index)] <= HEIGHT_BITS'(target_height);
			if (cmd.walk_en && moving) begin
				step_q[idx_q] <= ~step_q[idx_q];
				if (wrap) begin
					cnt_q[idx_q] <= '0;
					dir_q[idx_q] <= lower;
					pos_q[idx_q] <= nxt_pos;
				end else begin
					cnt_q[idx_q] <= cnt_inc[PPU_W-1:0];
				end
			end
		end
	end

	for (genvar b = 0; b < FIELD_W; b++) begin : g_out
		if (b < NUM_MOTORS) begin : g_on
			assign step_levels[b] = step_q[b];
			assign dir_levels[b]  = dir_q[b];
		end else begin : g_off
			assign step_levels[b] = 1'b0;
			assign dir_levels[b]  = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import msf_pkg::*;

	localparam int NUM_MOTORS = 15;
	localparam int GROUP_SIZE = 5;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		req_t        kind;
		logic [3:0]  motor;
		logic [15:0] height;
		logic [15:0] elapsed;
	} motor_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] steps;
		logic [FIELD_W-1:0] dirs;
	} motor_levels_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic req_type = 1'b0;
	logic [3:0] motor_index = '0;
	logic [15:0] target_height = '0;
	logic [15:0] elapsed_count = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic busy;
	logic done;
	logic [FIELD_W-1:0] step_levels;
	logic [FIELD_W-1:0] dir_levels;
	logic cfg_ready;

	multi_stepper_position_follower u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.motor_index(motor_index),
		.target_height(target_height),
		.elapsed_count(elapsed_count),
		.done(done),
		.step_levels(step_levels),
		.dir_levels(dir_levels),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predicted follower state and register copies
	logic [15:0] grp_delay [3] = '{RST_G0_DELAY, RST_G1_DELAY, RST_G2_DELAY};
	logic [7:0] unit_pulses = RST_PPU;
	logic [15:0] move_limit = RST_LIMIT;
	logic [15:0] tgt_h [NUM_MOTORS] = '{default: '0};
	logic [15:0] pos_h [NUM_MOTORS] = '{default: '0};
	logic [7:0] pulse_cnt [NUM_MOTORS] = '{default: '0};
	logic [FIELD_W-1:0] step_lv = '0;
	logic [FIELD_W-1:0] dir_bit = '0;

	motor_req_t pending_reqs[$];
	motor_levels_t expected_levels[$];
	int mismatches = 0;
	int cycles = 0;
	bit beat_taken = 1'b0;
	int burst_left = 4;
	int idle_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic motor_levels_t step_motors(input logic [15:0] elapsed);
		logic [2:0] open_g;
		logic [8:0] cnt;
		motor_levels_t lv;
		open_g[0] = elapsed > grp_delay[0];
		open_g[1] = open_g[0] && elapsed > grp_delay[1];
		open_g[2] = open_g[1] && elapsed > grp_delay[2];
		for (int m = 0; m < NUM_MOTORS; m++) begin
			if (open_g[m / GROUP_SIZE] && tgt_h[m] <= move_limit && tgt_h[m] != pos_h[m]) begin
				// count is compared before truncation to 8 bits
				cnt = pulse_cnt[m] + 9'd1;
				if (cnt > {1'b0, unit_pulses}) begin
					cnt = '0;
					dir_bit[m] = tgt_h[m] < pos_h[m];
					pos_h[m] = dir_bit[m] ? pos_h[m] - 16'd1 : pos_h[m] + 16'd1;
				end
				pulse_cnt[m] = cnt[7:0];
				step_lv[m] = ~step_lv[m];
			end
		end
		lv.steps = step_lv;
		lv.dirs = dir_bit;
		return lv;
	endfunction

	task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		$display("%0t %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic push_write(input logic [3:0] motor, input logic [15:0] height);
		motor_req_t r;
		r.kind = REQ_TARGET;
		r.motor = motor;
		r.height = height;
		r.elapsed = 16'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic push_tick(input logic [15:0] elapsed);
		motor_req_t r;
		r.kind = REQ_TICK;
		r.motor = 4'($urandom);
		r.height = 16'($urandom);
		r.elapsed = elapsed;
		pending_reqs.push_back(r);
	endtask

	// mostly in-range targets near the positions, a few wild ones
	task automatic add_random(input int count, input int tick_pct, input int tgt_max,
			input int el_lo, input int el_hi);
		logic [3:0] motor;
		logic [15:0] height;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99, 0) < tick_pct) begin
				push_tick(($urandom_range(7, 0) == 0) ? 16'($urandom)
						: 16'($urandom_range(el_hi, el_lo)));
			end else begin
				motor = ($urandom_range(19, 0) == 0) ? 4'($urandom_range(15, 8))
						: 4'($urandom_range(NUM_MOTORS - 1, 0));
				height = ($urandom_range(9, 0) == 0) ? 16'($urandom)
						: 16'($urandom_range(tgt_max, 0));
				push_write(motor, height);
			end
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_G0_DELAY: grp_delay[0] = val;
			CFG_G1_DELAY: grp_delay[1] = val;
			CFG_G2_DELAY: grp_delay[2] = val;
			CFG_PPU:      unit_pulses = val[7:0];
			CFG_LIMIT:    move_limit = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input int d0, input int d1, input int d2, input int ppu,
			input int limit);
		write_reg(CFG_G0_DELAY, 16'(d0));
		write_reg(CFG_G1_DELAY, 16'(d1));
		write_reg(CFG_G2_DELAY, 16'(d2));
		write_reg(CFG_PPU, 16'(ppu));
		write_reg(CFG_LIMIT, 16'(limit));
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || start || expected_levels.size() != 0);
		repeat (NUM_MOTORS + 8) @(posedge clk);
	endtask

	// request driver: bursts with random gaps, gap counted after the last beat of a burst
	always @(negedge clk) begin
		motor_req_t nxt;
		logic drive;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			drive = 1'b0;
			if (idle_left > 0) begin
				idle_left--;
			end else if (pending_reqs.size() > 0) begin
				nxt = pending_reqs.pop_front();
				drive = 1'b1;
				req_type <= nxt.kind;
				motor_index <= nxt.motor;
				target_height <= nxt.height;
				elapsed_count <= nxt.elapsed;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(12, 1);
					idle_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(20, 1);
				end
			end
			start <= drive;
		end
	end

	// accepted requests feed the predictor; done beats are checked in order
	always @(posedge clk) begin
		motor_levels_t want;
		if (!arst_n) begin
			beat_taken = 1'b0;
		end else begin
			beat_taken = start && !busy;
			if (beat_taken) begin
				if (req_type == REQ_TICK)
					expected_levels.push_back(step_motors(elapsed_count));
				else if (motor_index < NUM_MOTORS)
					tgt_h[motor_index] = target_height;
			end
			if (done) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("result beat with no tick pending", step_levels, '0);
				end else begin
					want = expected_levels.pop_front();
					if (step_levels !== want.steps)
						report_mismatch("step_levels", step_levels, want.steps);
					if (dir_levels !== want.dirs)
						report_mismatch("dir_levels", dir_levels, want.dirs);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_stepper_position_follower: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults: gates 10/11/12, limit 245
		push_tick(16'd0);
		push_write(4'd0, 16'd5);
		push_write(4'd4, 16'd245);
		push_write(4'd5, 16'd246);
		push_write(4'd6, 16'hFFFF);
		push_write(4'd14, 16'd1);
		push_write(4'hF, 16'd7);     // out of range, dropped
		push_write(4'd9, 16'd200);
		push_write(4'd10, 16'd0);    // already at target
		push_tick(16'd10);           // nothing open
		push_tick(16'd11);           // group 0 only
		push_tick(16'd12);           // groups 0 and 1
		push_tick(16'd13);           // all groups
		push_tick(16'hFFFF);
		push_write(4'd14, 16'hAAAA);
		push_write(4'd11, 16'h5555);
		push_tick(16'd13);
		push_tick(16'hFFFF);
		wait_drained();

		// move on every pulse, no limit
		set_regs(0, 0, 0, 0, 65535);
		add_random(200, 70, 40, 0, 8);
		wait_drained();

		// slowest stepping: needs long runs of ticks to see a unit move
		set_regs(0, 0, 0, 255, 65535);
		push_write(4'd1, 16'd60000);
		push_write(4'd7, 16'd30000);
		push_write(4'd12, 16'd45000);
		add_random(280, 95, 65535, 1, 65535);
		wait_drained();

		// nested gates; group 2 can never open
		set_regs(100, 200, 65535, 1, 20);
		add_random(150, 65, 30, 0, 400);
		wait_drained();

		// gates out of order
		set_regs(300, 100, 50, 2, 245);
		add_random(150, 65, 260, 0, 600);
		wait_drained();

		// zero limit: only motors heading to zero may move
		set_regs(0, 0, 0, 1, 0);
		add_random(60, 70, 3, 0, 65535);
		wait_drained();

		if (mismatches == 0)
			$display("multi_stepper_position_follower: match");
		else
			$display("multi_stepper_position_follower: mismatch");
		$finish;
	end

endmodule

>>> multi_stepper_position_follower.f
rtl/msf_pkg.sv
rtl/msf_ctrl.sv
rtl/msf_datapath.sv
rtl/multi_stepper_position_follower.sv
test/tb.sv
